FILE: rtl/phase_synced_event_scheduler_assert.svh
// Assertion macros shared by the scheduler RTL.
`ifndef PHASE_SYNCED_EVENT_SCHEDULER_ASSERT_SVH
`define PHASE_SYNCED_EVENT_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PSES_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PSES_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pses_pkg.sv
// Shared constants, codes and interface types of the phase-synced event scheduler.
package pses_pkg;

    localparam int PHASE_BITS_DEF = 16;

    localparam int TGT_W     = 16;
    localparam int PERIOD_W  = 15;
    localparam int SCALE_W   = 16;
    localparam int TIME_W    = 16;
    localparam int PHASE_W   = 15;
    localparam int EVENT_W   = 4;
    localparam int TASK_W    = 8;
    localparam int MODE_W    = 2;

    localparam int DIV_W     = 32;
    localparam int SHORT_W   = 17;
    localparam int DIVISOR_W = 15;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST     = PERIOD_W'(1000);
    localparam logic [PERIOD_W-1:0] CYCLE_POINTS_RST   = PERIOD_W'(512);
    localparam logic [PERIOD_W-1:0] SEGMENT_POINTS_RST = PERIOD_W'(64);
    localparam logic [SCALE_W-1:0]  BUS_SCALE_RST      = SCALE_W'(7500);

    localparam logic FUNC_SCHEDULE = 1'b0;
    localparam logic FUNC_TICK     = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_DELAY      = 2'd0,
        MODE_CROSS_ZERO = 2'd1,
        MODE_ZERO_POINT = 2'd2,
        MODE_RAW        = 2'd3
    } relay_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PWM_PERIOD     = 2'd0,
        CFG_CYCLE_POINTS   = 2'd1,
        CFG_SEGMENT_POINTS = 2'd2,
        CFG_BUS_SCALE      = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic                 start;
        logic                 short_len;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

    typedef struct packed {
        logic               valid;
        logic [TGT_W-1:0]   target;
        logic [EVENT_W-1:0] event_code;
        logic [TASK_W-1:0]  task_id;
    } slot_wr_t;

    // Left-align a short dividend so the divider runs only its own bit count.
    function automatic logic [DIV_W-1:0] short_dividend(input logic [SHORT_W-1:0] v);
        return {v, {(DIV_W - SHORT_W){1'b0}}};
    endfunction

endpackage

FILE: rtl/pses_divider.sv
// Serial restoring divider, one quotient bit per cycle, shared by all reductions.
module pses_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  pses_pkg::div_req_t req,
    output pses_pkg::div_rsp_t rsp
);
    import pses_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 zero_reg;
    logic                 short_reg;
    logic [DIV_W-1:0]     q_reg;
    logic [DIVISOR_W-1:0] r_reg;
    logic [DIVISOR_W-1:0] dvs_reg;

    logic [DIVISOR_W:0]   trial;
    logic                 ge;

    assign trial = {r_reg, q_reg[DIV_W-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                // zero divisor: finish at once with the dividend kept as remainder
                busy_reg <= (req.divisor != '0);
                done_reg <= (req.divisor == '0);
                cnt_reg  <= req.short_len ? DIV_CNT_W'(SHORT_W) : DIV_CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg     <= req.dividend;
            r_reg     <= '0;
            dvs_reg   <= req.divisor;
            zero_reg  <= (req.divisor == '0);
            short_reg <= req.short_len;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[DIV_W-2:0], ge};
            r_reg <= ge ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : trial[DIVISOR_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = zero_reg ? '0 : q_reg;
    assign rsp.rem  = zero_reg ? (short_reg ? DIV_W'(q_reg[DIV_W-1 -: SHORT_W]) : q_reg)
                               : DIV_W'(r_reg);

`include "phase_synced_event_scheduler_assert.svh"

    `PSES_ASSERT_IMP(a_start_idle, req.start, !busy_reg, "divider started while busy")
    `PSES_ASSERT_IMP(a_busy_not_done, busy_reg, !done_reg, "divider done while busy")
    `PSES_ASSERT_NXT(a_done_pulse, done_reg, !done_reg, "divider done held over one cycle")

endmodule

FILE: rtl/pses_slots.sv
// Two event slots: arm on schedule, match on tick, hand out fired events in slot order.
module pses_slots #(
    parameter int PHASE_BITS = pses_pkg::PHASE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pses_pkg::slot_wr_t              wr,
    input  logic                            tick_valid,
    input  logic [pses_pkg::PHASE_W-1:0]    tick_phase,
    input  logic [pses_pkg::PERIOD_W-1:0]   cycle_points,
    output logic                            busy,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [pses_pkg::TASK_W-1:0]     fire_task,
    output logic [pses_pkg::EVENT_W-1:0]    fire_event,
    output logic                            fire_slot,
    output logic                            last
);
    import pses_pkg::*;

    logic [1:0]            armed_reg;
    logic [1:0]            pend_reg;
    logic [PHASE_BITS-1:0] target_reg [2];
    logic [EVENT_W-1:0]    event_reg  [2];
    logic [TASK_W-1:0]     task_reg   [2];

    logic [1:0]            fire;
    logic                  wr_sel;
    logic                  out_acc;

    always_comb
    begin
        for (int s = 0; s < 2; s++)
        begin
            fire[s] = armed_reg[s]
                && ((TGT_W'(target_reg[s]) == TGT_W'(tick_phase))
                    || ((TGT_W'(target_reg[s]) >= TGT_W'(cycle_points))
                        && (tick_phase == '0)));
        end
    end

    // first slot if free, else overwrite the second
    assign wr_sel  = armed_reg[0];
    assign out_acc = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 2'b00;
            pend_reg  <= 2'b00;
        end
        else
        begin
            if (wr.valid)
            begin
                armed_reg[wr_sel] <= 1'b1;
            end
            else if (tick_valid)
            begin
                armed_reg <= armed_reg & ~fire;
                pend_reg  <= fire;
            end
            else if (out_acc)
            begin
                pend_reg <= pend_reg[0] ? {pend_reg[1], 1'b0} : 2'b00;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.valid)
        begin
            target_reg[wr_sel] <= wr.target[PHASE_BITS-1:0];
            event_reg[wr_sel]  <= wr.event_code;
            task_reg[wr_sel]   <= wr.task_id;
        end
    end

    assign busy       = (pend_reg != 2'b00);
    assign out_valid  = busy;
    assign fire_slot  = !pend_reg[0];
    assign fire_task  = pend_reg[0] ? task_reg[0]  : task_reg[1];
    assign fire_event = pend_reg[0] ? event_reg[0] : event_reg[1];
    assign last       = $onehot(pend_reg);

`include "phase_synced_event_scheduler_assert.svh"

    `PSES_ASSERT_IMP(a_tick_drained, tick_valid, pend_reg == 2'b00, "tick while words pending")
    `PSES_ASSERT_NXT(a_wr_arms_first, wr.valid, armed_reg[0], "write left first slot free")
    `PSES_ASSERT_NXT(a_fired_freed, tick_valid, (armed_reg & pend_reg) == 2'b00,
        "fired slot still armed")

endmodule

FILE: rtl/phase_synced_event_scheduler.sv
// Schedule request: a raw point is written directly; otherwise one 16x16 multiply
// (two for zero point), a 32-step division and one to three 17-step reductions on the
// serial divider. Input stall stays high until done.
// Phase tick: fired words leave from a registered slot stage, first in the next cycle,
// one per cycle while out_stall is low, and input stalls until all are taken.
// Reset: async active low; slots free, sequencer idle, registers at their defaults.
module phase_synced_event_scheduler #(
    parameter int PHASE_BITS = pses_pkg::PHASE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              func,
    input  logic [pses_pkg::MODE_W-1:0]       relay_mode,
    input  logic [pses_pkg::TIME_W-1:0]       time_value,
    input  logic [pses_pkg::EVENT_W-1:0]      event_code,
    input  logic [pses_pkg::TASK_W-1:0]       task_id,
    input  logic [pses_pkg::PHASE_W-1:0]      phase,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [pses_pkg::TASK_W-1:0]       fire_task,
    output logic [pses_pkg::EVENT_W-1:0]      fire_event,
    output logic                              fire_slot,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pses_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pses_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pses_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_POST,
        S_DIV_GO,
        S_DIV_WAIT,
        S_WRITE
    } state_t;

    typedef enum logic [1:0] {
        ST_T,
        ST_U,
        ST_Q,
        ST_FIN
    } step_t;

    state_t                state_reg, state_next;
    step_t                 step_reg, step_next;

    logic [PERIOD_W-1:0]   pwm_period_reg;
    logic [PERIOD_W-1:0]   cycle_points_reg;
    logic [PERIOD_W-1:0]   segment_points_reg;
    logic [SCALE_W-1:0]    bus_scale_reg;

    relay_mode_t           mode_reg, mode_next;
    logic [TIME_W-1:0]     tv_reg, tv_next;
    logic [PHASE_W-1:0]    ph_reg, ph_next;
    logic [EVENT_W-1:0]    ev_reg, ev_next;
    logic [TASK_W-1:0]     task_reg, task_next;
    logic [TGT_W-1:0]      u_reg, u_next;
    logic [TGT_W-1:0]      q2_reg, q2_next;
    logic [DIV_W-1:0]      prod_reg, prod_next;
    logic [DIV_W-1:0]      dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic                  short_reg, short_next;
    logic [TGT_W-1:0]      tgt_reg, tgt_next;

    logic                  in_acc;
    logic                  slots_busy;
    logic [TGT_W-1:0]      q2_inc;
    logic [TIME_W-1:0]     mul_a;
    logic [SCALE_W-1:0]    mul_b;
    logic [DIV_W-1:0]      mul_out;
    logic [PHASE_BITS-1:0] snap_val;

    div_req_t              div_req;
    div_rsp_t              div_rsp;
    slot_wr_t              slot_wr;

    assign in_stall  = (state_reg != S_IDLE) || slots_busy;
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // shared multiplier: time conversion first, segment snap later
    assign q2_inc  = q2_reg + TGT_W'(1);
    assign mul_a   = (step_reg == ST_T) ? tv_reg : TIME_W'(q2_inc);
    assign mul_b   = (step_reg == ST_T) ? bus_scale_reg : SCALE_W'(segment_points_reg);
    assign mul_out = mul_a * mul_b;

    assign snap_val   = PHASE_BITS'(prod_reg) - PHASE_BITS'(u_reg);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        mode_next  = mode_reg;
        tv_next    = tv_reg;
        ph_next    = ph_reg;
        ev_next    = ev_reg;
        task_next  = task_reg;
        u_next     = u_reg;
        q2_next    = q2_reg;
        prod_next  = prod_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        short_next = short_reg;
        tgt_next   = tgt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (func == FUNC_SCHEDULE))
                begin
                    mode_next = relay_mode_t'(relay_mode);
                    tv_next   = time_value;
                    ph_next   = phase;
                    ev_next   = event_code;
                    task_next = task_id;
                    step_next = ST_T;
                    if (relay_mode_t'(relay_mode) == MODE_RAW)
                    begin
                        tgt_next   = TGT_W'(time_value[PHASE_BITS-1:0]);
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = mul_out;
                state_next = S_POST;
            end
            S_POST:
            begin
                if (step_reg == ST_T)
                begin
                    dvd_next   = prod_reg;
                    dvs_next   = pwm_period_reg;
                    short_next = 1'b0;
                end
                else
                begin
                    dvd_next   = short_dividend(SHORT_W'(snap_val));
                    dvs_next   = cycle_points_reg;
                    short_next = 1'b1;
                    step_next  = ST_FIN;
                end
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    unique case (step_reg)
                        ST_T:
                        begin
                            short_next = 1'b1;
                            state_next = S_DIV_GO;
                            unique case (mode_reg)
                                MODE_DELAY:
                                begin
                                    dvd_next  = short_dividend(
                                        SHORT_W'(div_rsp.quot[PHASE_BITS-1:0])
                                        + SHORT_W'(ph_reg) + SHORT_W'(1));
                                    dvs_next  = cycle_points_reg;
                                    step_next = ST_FIN;
                                end
                                MODE_CROSS_ZERO:
                                begin
                                    dvd_next  = short_dividend(
                                        SHORT_W'(div_rsp.quot[PHASE_BITS-1:0]));
                                    dvs_next  = cycle_points_reg;
                                    step_next = ST_U;
                                end
                                MODE_ZERO_POINT:
                                begin
                                    dvd_next  = short_dividend(
                                        SHORT_W'(div_rsp.quot[PHASE_BITS-1:0]));
                                    dvs_next  = segment_points_reg;
                                    step_next = ST_U;
                                end
                                MODE_RAW:
                                begin
                                    tgt_next   = TGT_W'(tv_reg[PHASE_BITS-1:0]);
                                    state_next = S_WRITE;
                                end
                            endcase
                        end
                        ST_U:
                        begin
                            u_next     = div_rsp.rem[TGT_W-1:0];
                            short_next = 1'b1;
                            state_next = S_DIV_GO;
                            if (mode_reg == MODE_CROSS_ZERO)
                            begin
                                dvd_next  = short_dividend(SHORT_W'(
                                    PHASE_BITS'(cycle_points_reg)
                                    - div_rsp.rem[PHASE_BITS-1:0]));
                                dvs_next  = cycle_points_reg;
                                step_next = ST_FIN;
                            end
                            else
                            begin
                                dvd_next  = short_dividend(SHORT_W'(div_rsp.rem[TGT_W-1:0])
                                    + SHORT_W'(ph_reg) + SHORT_W'(2));
                                dvs_next  = segment_points_reg;
                                step_next = ST_Q;
                            end
                        end
                        ST_Q:
                        begin
                            q2_next    = div_rsp.quot[TGT_W-1:0];
                            state_next = S_MUL;
                        end
                        ST_FIN:
                        begin
                            tgt_next   = TGT_W'(div_rsp.rem[PHASE_BITS-1:0]);
                            state_next = S_WRITE;
                        end
                    endcase
                end
            end
            S_WRITE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            step_reg           <= ST_T;
            pwm_period_reg     <= PWM_PERIOD_RST;
            cycle_points_reg   <= CYCLE_POINTS_RST;
            segment_points_reg <= SEGMENT_POINTS_RST;
            bus_scale_reg      <= BUS_SCALE_RST;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_PWM_PERIOD:     pwm_period_reg     <= cfg_data[PERIOD_W-1:0];
                    CFG_CYCLE_POINTS:   cycle_points_reg   <= cfg_data[PERIOD_W-1:0];
                    CFG_SEGMENT_POINTS: segment_points_reg <= cfg_data[PERIOD_W-1:0];
                    CFG_BUS_SCALE:      bus_scale_reg      <= cfg_data[SCALE_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        tv_reg    <= tv_next;
        ph_reg    <= ph_next;
        ev_reg    <= ev_next;
        task_reg  <= task_next;
        u_reg     <= u_next;
        q2_reg    <= q2_next;
        prod_reg  <= prod_next;
        dvd_reg   <= dvd_next;
        dvs_reg   <= dvs_next;
        short_reg <= short_next;
        tgt_reg   <= tgt_next;
    end

    assign div_req.start     = (state_reg == S_DIV_GO);
    assign div_req.short_len = short_reg;
    assign div_req.dividend  = dvd_reg;
    assign div_req.divisor   = dvs_reg;

    pses_divider u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    assign slot_wr.valid      = (state_reg == S_WRITE);
    assign slot_wr.target     = tgt_reg;
    assign slot_wr.event_code = ev_reg;
    assign slot_wr.task_id    = task_reg;

    pses_slots #(
        .PHASE_BITS (PHASE_BITS)
    ) u_slots (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (slot_wr),
        .tick_valid   (in_acc && (func == FUNC_TICK)),
        .tick_phase   (phase),
        .cycle_points (cycle_points_reg),
        .busy         (slots_busy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .fire_task    (fire_task),
        .fire_event   (fire_event),
        .fire_slot    (fire_slot),
        .last         (last)
    );

endmodule
